/* rtl/cbm_pkg.sv */
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int BANK_BITS     = 9;
    localparam int STEP_BITS     = 3;
    localparam int DIV_STEPS     = BANK_BITS / STEP_BITS;
    localparam int STEP_CNT_W    = $clog2(DIV_STEPS);
    localparam int ROM_COUNT_W   = 10;
    localparam int RAM_COUNT_W   = 5;
    localparam int RAM_BANK_W    = 4;
    localparam int ROM_OFFSET_W  = 14;
    localparam int RAM_OFFSET_W  = 13;
    localparam int ADDR_W        = 16;
    localparam int PHYS_W        = 23;
    localparam int DATA_W        = 8;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 13;

    localparam logic [ROM_COUNT_W-1:0]  MAX_ROM_BANKS    = 10'd512;
    localparam logic [DATA_W-1:0]       RAM_ENABLE_KEY   = 8'h0A;

    localparam logic [ROM_COUNT_W-1:0]  ROM_COUNT_RESET  = 10'd2;
    localparam logic [RAM_COUNT_W-1:0]  RAM_COUNT_RESET  = 5'd0;
    localparam logic [RAM_OFFSET_W-1:0] RAM_ADDR_MASK_RESET = 13'h1FFF;

    localparam logic [CFG_INDEX_W-1:0]  CFG_ROM_BANK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0]  CFG_RAM_BANK_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0]  CFG_RAM_ADDR_MASK  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0]  CFG_RUMBLE_PRESENT = 2'd3;

    typedef enum logic [1:0] {
        TARGET_OPEN = 2'd0,
        TARGET_ROM  = 2'd1,
        TARGET_RAM  = 2'd2
    } target_t;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic load_result;
    } ctrl_cmd_t;

endpackage

/* rtl/cbm_controller.sv */
`timescale 1ns / 1ps

module cbm_controller (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output cbm_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIV    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [cbm_pkg::STEP_CNT_W-1:0]    step_cnt_reg, step_cnt_next;
    logic                              m_valid_reg, m_valid_next;
    logic                              out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    step_cnt_next = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == cbm_pkg::STEP_CNT_W'(cbm_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

/* rtl/cbm_datapath.sv */
`timescale 1ns / 1ps

module cbm_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cbm_pkg::ctrl_cmd_t                  cmd,
    input  logic                                cfg_valid,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_command,
    input  logic [cbm_pkg::ADDR_W-1:0]          s_address,
    input  logic [cbm_pkg::DATA_W-1:0]          s_write_data,
    output logic [1:0]                          m_target,
    output logic [cbm_pkg::PHYS_W-1:0]          m_physical_address,
    output logic                                m_ram_write,
    output logic [cbm_pkg::DATA_W-1:0]          m_store_data
);

    localparam int BB = cbm_pkg::BANK_BITS;

    // configuration
    logic [cbm_pkg::ROM_COUNT_W-1:0]  rom_count_reg;
    logic [cbm_pkg::RAM_COUNT_W-1:0]  ram_count_reg;
    logic [cbm_pkg::RAM_OFFSET_W-1:0] ram_addr_mask_reg;
    logic                             rumble_reg;

    // bank state
    logic                             ram_enabled_reg;
    logic [7:0]                       rom_low_reg;
    logic                             rom_high_reg;
    logic [cbm_pkg::RAM_BANK_W-1:0]   ram_bank_reg;

    // latched item
    logic                             cmd_write_reg;
    logic [cbm_pkg::ADDR_W-1:0]       addr_reg;
    logic [cbm_pkg::DATA_W-1:0]       data_reg;

    // remainder unit
    logic [BB-1:0]                    quot_reg, quot_next;
    logic [BB-1:0]                    rem_reg, rem_next;
    logic [cbm_pkg::ROM_COUNT_W-1:0]  divisor_reg;

    // result
    logic [1:0]                       target_reg;
    logic [cbm_pkg::PHYS_W-1:0]       phys_reg;
    logic                             ram_write_reg;
    logic [cbm_pkg::DATA_W-1:0]       store_data_reg;

    logic                             s_in_ram;
    logic [cbm_pkg::ROM_COUNT_W-1:0]  rom_divisor;
    logic [BB:0]                      shifted;
    logic                             in_ram;
    logic                             ram_usable;
    cbm_pkg::target_t                 target_next;
    logic [cbm_pkg::PHYS_W-1:0]       phys_next;
    logic                             ram_write_next;
    logic [cbm_pkg::DATA_W-1:0]       store_data_next;
    logic [cbm_pkg::RAM_OFFSET_W-1:0] ram_offset;
    logic [BB-1:0]                    bank_rem;

    assign s_in_ram   = s_address inside {[16'hA000:16'hBFFF]};
    assign rom_divisor = (rom_count_reg > cbm_pkg::MAX_ROM_BANKS) ?
                         cbm_pkg::MAX_ROM_BANKS : rom_count_reg;

    // restoring remainder, several quotient bits per cycle
    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        shifted   = '0;
        for (int i = 0; i < cbm_pkg::STEP_BITS; i++) begin
            shifted   = {rem_next, quot_next[BB-1]};
            quot_next = {quot_next[BB-2:0], 1'b0};
            if (shifted >= divisor_reg) begin
                shifted = shifted - divisor_reg;
            end
            rem_next = shifted[BB-1:0];
        end
    end

    assign in_ram     = addr_reg inside {[16'hA000:16'hBFFF]};
    assign ram_usable = (ram_count_reg != '0) && ram_enabled_reg;
    assign bank_rem   = (divisor_reg == '0) ? '0 : rem_reg;
    assign ram_offset = addr_reg[cbm_pkg::RAM_OFFSET_W-1:0] & ram_addr_mask_reg;

    always_comb begin
        target_next     = cbm_pkg::TARGET_OPEN;
        phys_next       = '0;
        ram_write_next  = 1'b0;
        store_data_next = '0;
        if (!cmd_write_reg && !addr_reg[15] && !addr_reg[14]) begin
            target_next = cbm_pkg::TARGET_ROM;
            phys_next   = cbm_pkg::PHYS_W'(addr_reg);
        end else if (!cmd_write_reg && !addr_reg[15]) begin
            target_next = cbm_pkg::TARGET_ROM;
            phys_next   = {bank_rem, addr_reg[cbm_pkg::ROM_OFFSET_W-1:0]};
        end else if (in_ram && ram_usable) begin
            target_next     = cbm_pkg::TARGET_RAM;
            phys_next       = cbm_pkg::PHYS_W'({bank_rem[cbm_pkg::RAM_BANK_W-1:0],
                                                ram_offset});
            ram_write_next  = cmd_write_reg;
            store_data_next = cmd_write_reg ? data_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_count_reg     <= cbm_pkg::ROM_COUNT_RESET;
            ram_count_reg     <= cbm_pkg::RAM_COUNT_RESET;
            ram_addr_mask_reg <= cbm_pkg::RAM_ADDR_MASK_RESET;
            rumble_reg        <= 1'b0;
            ram_enabled_reg   <= 1'b0;
            rom_low_reg       <= 8'd1;
            rom_high_reg      <= 1'b0;
            ram_bank_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    cbm_pkg::CFG_ROM_BANK_COUNT:
                        rom_count_reg <= cfg_data[cbm_pkg::ROM_COUNT_W-1:0];
                    cbm_pkg::CFG_RAM_BANK_COUNT:
                        ram_count_reg <= cfg_data[cbm_pkg::RAM_COUNT_W-1:0];
                    cbm_pkg::CFG_RAM_ADDR_MASK:
                        ram_addr_mask_reg <= cfg_data[cbm_pkg::RAM_OFFSET_W-1:0];
                    cbm_pkg::CFG_RUMBLE_PRESENT:
                        rumble_reg    <= cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (cmd.load_item && s_command && !s_address[15]) begin
                case (s_address[14:12])
                    3'b000, 3'b001:
                        ram_enabled_reg <= (s_write_data == cbm_pkg::RAM_ENABLE_KEY);
                    3'b010:
                        rom_low_reg <= s_write_data;
                    3'b011:
                        rom_high_reg <= s_write_data[0];
                    3'b100, 3'b101:
                        ram_bank_reg <= rumble_reg ? {1'b0, s_write_data[2:0]} :
                                                     s_write_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_write_reg <= s_command;
            addr_reg      <= s_address;
            data_reg      <= s_write_data;
            rem_reg       <= '0;
            if (s_in_ram) begin
                quot_reg    <= BB'(ram_bank_reg);
                divisor_reg <= cbm_pkg::ROM_COUNT_W'(ram_count_reg);
            end else begin
                quot_reg    <= {rom_high_reg, rom_low_reg};
                divisor_reg <= rom_divisor;
            end
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        if (cmd.load_result) begin
            target_reg     <= target_next;
            phys_reg       <= phys_next;
            ram_write_reg  <= ram_write_next;
            store_data_reg <= store_data_next;
        end
    end

    assign m_target           = target_reg;
    assign m_physical_address = phys_reg;
    assign m_ram_write        = ram_write_reg;
    assign m_store_data       = store_data_reg;

endmodule

/* rtl/cartridge_bank_mapper_core.sv */
`timescale 1ns / 1ps

// bank controller for game cartridges: each item is one cpu bus access that
// comes back as a rom or ram byte address, or as open bus while a register
// write updates the bank state. an item is taken while s_ready is high, the
// bank number is reduced modulo the rom or ram bank count by a shared
// remainder unit that retires three bits per cycle, and the result is
// registered once the output register is free. the next item is taken
// while a result still waits on m_ready. configuration writes are always
// accepted and should be made only while no item is in flight.
module cartridge_bank_mapper_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_command,
    input  logic [cbm_pkg::ADDR_W-1:0]         s_address,
    input  logic [cbm_pkg::DATA_W-1:0]         s_write_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_target,
    output logic [cbm_pkg::PHYS_W-1:0]         m_physical_address,
    output logic                               m_ram_write,
    output logic [cbm_pkg::DATA_W-1:0]         m_store_data
);

    cbm_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    cbm_controller u_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    cbm_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_command          (s_command),
        .s_address          (s_address),
        .s_write_data       (s_write_data),
        .m_target           (m_target),
        .m_physical_address (m_physical_address),
        .m_ram_write        (m_ram_write),
        .m_store_data       (m_store_data)
    );

endmodule

/* tb/sv/bank_map_checker.sv */
`timescale 1ns / 1ps

module bank_map_checker
    import cbm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_command,
    input  logic [ADDR_W-1:0]      s_address,
    input  logic [DATA_W-1:0]      s_write_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [1:0]             m_target,
    input  logic [PHYS_W-1:0]      m_physical_address,
    input  logic                   m_ram_write,
    input  logic [DATA_W-1:0]      m_store_data,
    output int                     mismatch_count,
    output int                     results_outstanding
);

    localparam logic [ADDR_W-1:0] UPPER_ROM_BASE = 16'h4000;
    localparam logic [ADDR_W-1:0] RAM_WINDOW_BASE = 16'hA000;
    localparam logic [ADDR_W-1:0] RAM_WINDOW_END = 16'hC000;
    localparam int unsigned ROM_BANK_BYTES = 16384;
    localparam int unsigned RAM_BANK_BYTES = 8192;

    typedef struct packed {
        target_t           target;
        logic [PHYS_W-1:0] phys;
        logic              ram_write;
        logic [DATA_W-1:0] store_data;
    } bus_result_t;

    // cartridge configuration
    logic [ROM_COUNT_W-1:0]  rom_count;
    logic [RAM_COUNT_W-1:0]  ram_count;
    logic [RAM_OFFSET_W-1:0] ram_addr_mask;
    logic                    rumble;

    // bank state
    logic                  ram_on;
    logic [7:0]            rom_bank_lo;
    logic                  rom_bank_hi;
    logic [RAM_BANK_W-1:0] ram_bank;

    bus_result_t mapped_q[$];
    bus_result_t want;

    initial begin
        mismatch_count = 0;
        results_outstanding = 0;
    end

    function automatic logic [PHYS_W-1:0] upper_rom_base();
        int unsigned count;
        int unsigned bank;
        count = rom_count;
        bank = {rom_bank_hi, rom_bank_lo};
        if (count > MAX_ROM_BANKS)
            count = MAX_ROM_BANKS;
        if (count == 0)
            return '0;
        return PHYS_W'((bank % count) * ROM_BANK_BYTES);
    endfunction

    function automatic logic [PHYS_W-1:0] ram_byte_addr(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] window_off;
        int unsigned bank;
        window_off = addr - RAM_WINDOW_BASE;
        bank = ram_bank % ram_count;
        return PHYS_W'((window_off[RAM_OFFSET_W-1:0] & ram_addr_mask) +
                       bank * RAM_BANK_BYTES);
    endfunction

    function automatic bus_result_t map_access(logic is_write, logic [ADDR_W-1:0] addr,
                                               logic [DATA_W-1:0] data);
        bus_result_t r;
        logic in_ram;
        logic ram_usable;
        r = '0;
        r.target = TARGET_OPEN;
        in_ram = (addr >= RAM_WINDOW_BASE) && (addr < RAM_WINDOW_END);
        ram_usable = (ram_count != 0) && ram_on;
        if (is_write) begin
            if (!addr[15]) begin
                case (addr[14:12])
                    3'd0, 3'd1: ram_on = (data == RAM_ENABLE_KEY);
                    3'd2: rom_bank_lo = data;
                    3'd3: rom_bank_hi = data[0];
                    3'd4, 3'd5: ram_bank = rumble ? {1'b0, data[2:0]} : data[3:0];
                    default: ;
                endcase
            end else if (in_ram && ram_usable) begin
                r.target = TARGET_RAM;
                r.phys = ram_byte_addr(addr);
                r.ram_write = 1'b1;
                r.store_data = data;
            end
        end else begin
            if (addr < UPPER_ROM_BASE) begin
                r.target = TARGET_ROM;
                r.phys = PHYS_W'(addr);
            end else if (!addr[15]) begin
                r.target = TARGET_ROM;
                r.phys = PHYS_W'(addr[ROM_OFFSET_W-1:0]) + upper_rom_base();
            end else if (in_ram && ram_usable) begin
                r.target = TARGET_RAM;
                r.phys = ram_byte_addr(addr);
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            rom_count = ROM_COUNT_RESET;
            ram_count = RAM_COUNT_RESET;
            ram_addr_mask = RAM_ADDR_MASK_RESET;
            rumble = 1'b0;
            ram_on = 1'b0;
            rom_bank_lo = 8'd1;
            rom_bank_hi = 1'b0;
            ram_bank = '0;
            mapped_q.delete();
            results_outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ROM_BANK_COUNT: rom_count = cfg_data[ROM_COUNT_W-1:0];
                    CFG_RAM_BANK_COUNT: ram_count = cfg_data[RAM_COUNT_W-1:0];
                    CFG_RAM_ADDR_MASK:  ram_addr_mask = cfg_data[RAM_OFFSET_W-1:0];
                    CFG_RUMBLE_PRESENT: rumble = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (mapped_q.size() == 0) begin
                    $error("result item with nothing expected");
                    mismatch_count++;
                end else begin
                    want = mapped_q.pop_front();
                    if (m_target !== want.target) begin
                        $error("m_target: expected %0d, got %0d", want.target, m_target);
                        mismatch_count++;
                    end
                    if (m_physical_address !== want.phys) begin
                        $error("m_physical_address: expected 0x%0h, got 0x%0h",
                               want.phys, m_physical_address);
                        mismatch_count++;
                    end
                    if (m_ram_write !== want.ram_write) begin
                        $error("m_ram_write: expected %0d, got %0d",
                               want.ram_write, m_ram_write);
                        mismatch_count++;
                    end
                    if (m_store_data !== want.store_data) begin
                        $error("m_store_data: expected 0x%0h, got 0x%0h",
                               want.store_data, m_store_data);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                mapped_q.push_back(map_access(s_command, s_address, s_write_data));
            results_outstanding <= mapped_q.size();
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import cbm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES = 14;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int HOLD_CYCLES = 300;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROM_BANK_COUNT;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_command = 1'b0;
    logic [ADDR_W-1:0]      s_address = '0;
    logic [DATA_W-1:0]      s_write_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_target;
    logic [PHYS_W-1:0]      m_physical_address;
    logic                   m_ram_write;
    logic [DATA_W-1:0]      m_store_data;

    int   mismatch_count;
    int   results_outstanding;
    int   cycle_count = 0;
    logic sender_idles = 1'b1;
    logic receiver_idles = 1'b1;
    logic hold_pending = 1'b0;
    int   hold_left = 0;

    cartridge_bank_mapper_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_address          (s_address),
        .s_write_data       (s_write_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_target           (m_target),
        .m_physical_address (m_physical_address),
        .m_ram_write        (m_ram_write),
        .m_store_data       (m_store_data)
    );

    bank_map_checker checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_command           (s_command),
        .s_address           (s_address),
        .s_write_data        (s_write_data),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_target            (m_target),
        .m_physical_address  (m_physical_address),
        .m_ram_write         (m_ram_write),
        .m_store_data        (m_store_data),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side: random or no back-pressure, long hold-off on request
    always @(posedge aclk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (receiver_idles) begin
            m_ready <= ($urandom_range(99) >= 30);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        if (sender_idles) begin
            while ($urandom_range(99) < 30) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_address <= addr;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_random_access();
        int unsigned pick;
        logic cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        pick = $urandom_range(99);
        cmd = 1'b1;
        data = DATA_W'($urandom);
        if (pick < 15) begin
            addr = ADDR_W'($urandom_range(16'h1FFF));
            if ($urandom_range(99) < 60)
                data = RAM_ENABLE_KEY;
        end else if (pick < 30) begin
            addr = ADDR_W'($urandom_range(16'h2FFF, 16'h2000));
        end else if (pick < 38) begin
            addr = ADDR_W'($urandom_range(16'h3FFF, 16'h3000));
        end else if (pick < 48) begin
            addr = ADDR_W'($urandom_range(16'h5FFF, 16'h4000));
        end else if (pick < 65) begin
            cmd = 1'b0;
            addr = ADDR_W'($urandom_range(16'h7FFF));
        end else if (pick < 85) begin
            cmd = 1'($urandom);
            addr = ADDR_W'($urandom_range(16'hBFFF, 16'hA000));
        end else begin
            cmd = 1'($urandom);
            addr = ADDR_W'($urandom);
        end
        send_access(cmd, addr, data);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    // unused upper bits of count and rumble writes carry random junk
    task automatic apply_config(input logic [ROM_COUNT_W-1:0] rom_banks,
                                input logic [RAM_COUNT_W-1:0] ram_banks,
                                input logic [RAM_OFFSET_W-1:0] mask,
                                input logic rumble_on);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        put_reg(CFG_ROM_BANK_COUNT, {junk[CFG_DATA_W-1:ROM_COUNT_W], rom_banks});
        put_reg(CFG_RAM_BANK_COUNT, {junk[CFG_DATA_W-1:RAM_COUNT_W], ram_banks});
        put_reg(CFG_RAM_ADDR_MASK, mask);
        put_reg(CFG_RUMBLE_PRESENT, {junk[CFG_DATA_W-1:1], rumble_on});
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [ROM_COUNT_W-1:0] rom_banks;
        logic [RAM_COUNT_W-1:0] ram_banks;
        if ($urandom_range(99) < 15)
            rom_banks = ROM_COUNT_W'($urandom);
        else
            rom_banks = ROM_COUNT_W'($urandom_range(512, 2));
        if ($urandom_range(99) < 15)
            ram_banks = RAM_COUNT_W'($urandom);
        else
            ram_banks = RAM_COUNT_W'($urandom_range(16));
        apply_config(rom_banks, ram_banks, RAM_OFFSET_W'($urandom), 1'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: two rom banks, no ram
        send_access(1'b0, 16'h4000, 8'h00);
        send_access(1'b1, 16'h0000, RAM_ENABLE_KEY);
        send_access(1'b0, 16'hA000, 8'h00);
        wait_drained();
        apply_config(10'd512, 5'd16, 13'h1FFF, 1'b0);

        send_access(1'b0, 16'h0000, 8'hFF);
        send_access(1'b0, 16'h3FFF, 8'h00);
        send_access(1'b0, 16'hA000, 8'h00);
        send_access(1'b1, 16'hBFFF, 8'hFF);
        send_access(1'b1, 16'h2000, 8'hFF);
        send_access(1'b1, 16'h3000, 8'h01);
        send_access(1'b0, 16'h7FFF, 8'h00);
        send_access(1'b1, 16'h3FFF, 8'hFE);
        send_access(1'b0, 16'h4000, 8'h00);
        send_access(1'b1, 16'h4000, 8'hFF);
        send_access(1'b0, 16'hA123, 8'h00);
        send_access(1'b1, 16'h5FFF, 8'h00);
        send_access(1'b0, 16'h8000, 8'h00);
        send_access(1'b0, 16'h9FFF, 8'h00);
        send_access(1'b0, 16'hC000, 8'h00);
        send_access(1'b0, 16'hFFFF, 8'h00);
        send_access(1'b1, 16'h6000, 8'hFF);
        send_access(1'b1, 16'h8000, 8'h12);
        send_access(1'b1, 16'hC000, 8'h34);
        send_access(1'b1, 16'hFFFF, 8'h55);
        send_access(1'b1, 16'h1FFF, 8'h00);
        send_access(1'b0, 16'hBFFF, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: apply_config(10'd512, 5'd16, 13'h1FFF, 1'b0);
                1: apply_config(10'd0, 5'd0, 13'h0000, 1'b1);
                2: apply_config(10'd1023, 5'd31, 13'h1FFF, 1'b1);
                3: apply_config(10'd1, 5'd1, 13'h1555, 1'b0);
                4: apply_config(10'd2, 5'd16, 13'h0FFF, 1'b1);
                default: random_config();
            endcase
            sender_idles = (phase != 5);
            receiver_idles = (phase != 5);
            if (phase == 7)
                hold_pending = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_access();
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
